/* sv/text_to_unsigned64_parser_assert.svh */
// Assertion macros for the text-to-unsigned parser RTL.
`ifndef TEXT_TO_UNSIGNED64_PARSER_ASSERT_SVH
`define TEXT_TO_UNSIGNED64_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define TU64_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition holds in the cycle after an antecedent.
`define TU64_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TU64_ASSERT(label, clk, rst, prop, msg)
`define TU64_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* sv/tu64_pkg.sv */
// Shared types, constants and helpers of the text-to-unsigned parser.
`default_nettype none
package tu64_pkg;

  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned VALUE_W         = 64;
  localparam int unsigned BASE_W          = 6;
  localparam int unsigned OFFSET_W        = 12;
  localparam int unsigned MAX_TEXT_LENGTH = 4095;
  localparam int unsigned POS_W           = $clog2(MAX_TEXT_LENGTH + 1);
  localparam int unsigned PROD_W          = VALUE_W + BASE_W;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [VALUE_W-1:0] ALL_ONES = '1;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

  // Radix codes
  localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCTAL   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DECIMAL = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;

  // Register index of number_base
  localparam logic [APB_ADDR_W-3:0] REG_NUMBER_BASE = 1'b0;

  typedef enum logic [3:0] {
    PH_SKIP         = 4'b0001,
    PH_AFTER_SIGN   = 4'b0010,
    PH_ZERO_PENDING = 4'b0100,
    PH_DIGITS       = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE = 2'd0,
    DS_SEEN = 2'd1,
    DS_OVER = 2'd2
  } digit_status_t;

  typedef struct packed {
    phase_t              phase;
    logic [VALUE_W-1:0]  acc;
    logic [BASE_W-1:0]   base;
    logic                minus;
    digit_status_t       dstat;
    logic [POS_W-1:0]    pos;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase: PH_SKIP,
    acc:   '0,
    base:  '0,
    minus: 1'b0,
    dstat: DS_NONE,
    pos:   '0
  };

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic                overflow;
    logic                digits_seen;
    logic [OFFSET_W-1:0] end_offset;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_out_t;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] val;
  } digit_t;

  // Map a byte to its digit value; letters count from ten in either case.
  function automatic digit_t decode_digit(input logic [CHAR_W-1:0] b);
    digit_t d;
    d.ok  = 1'b0;
    d.val = '0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d.ok  = 1'b1;
      d.val = BASE_W'(b - CH_ZERO);
    end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      d.ok  = 1'b1;
      d.val = BASE_W'(b - CH_UPPER_A + CHAR_W'(10));
    end else if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
      d.ok  = 1'b1;
      d.val = BASE_W'(b - CH_LOWER_A + CHAR_W'(10));
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* sv/tu64_byte_if.sv */
// Valid/ready channel carrying one text byte per word.
`default_nettype none
interface tu64_byte_if import tu64_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface
`default_nettype wire

/* sv/tu64_result_if.sv */
// Valid/ready channel carrying one parsed number per word.
`default_nettype none
interface tu64_result_if import tu64_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic                overflow;
  logic                digits_seen;
  logic [OFFSET_W-1:0] end_offset;

  modport source (output valid, output value, output overflow, output digits_seen,
                  output end_offset, input ready);
  modport sink   (input valid, input value, input overflow, input digits_seen,
                  input end_offset, output ready);
endinterface
`default_nettype wire

/* sv/tu64_apb_regs.sv */
// APB register file holding the number_base configuration register.
`default_nettype none
module tu64_apb_regs import tu64_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [BASE_W-1:0]     number_base
);

  logic sel_base;

  assign pready   = 1'b1;
  assign sel_base = (paddr[APB_ADDR_W-1:2] == REG_NUMBER_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_DECIMAL;
    end else if (psel && penable && pwrite && pready && sel_base) begin
      number_base <= pwdata[BASE_W-1:0];
    end
  end

  assign prdata = sel_base ? {{(APB_DATA_W - BASE_W){1'b0}}, number_base} : '0;

endmodule
`default_nettype wire

/* sv/tu64_parse_step.sv */
// Next-state and result logic for one text byte of the parser.
`default_nettype none
module tu64_parse_step import tu64_pkg::*; (
  input  parse_state_t      st,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [BASE_W-1:0] cfg_base,
  output parse_state_t      nxt,
  output step_out_t         out
);

  digit_t                dg;
  logic                  do_cand;
  logic [BASE_W-1:0]     cbase;
  digit_status_t         cds;
  logic                  is_digit;
  logic [PROD_W-1:0]     prod;
  logic [POS_W:0]        off;
  logic [POS_W+OFFSET_W:0] off_ext;

  assign dg       = decode_digit(char_code);
  assign is_digit = dg.ok && (dg.val < cbase);
  // One narrow multiply-add; any bit above the word means overflow
  assign prod = PROD_W'(st.acc) * PROD_W'(cbase) + PROD_W'(dg.val);

  always_comb begin
    nxt      = st;
    out      = '0;
    do_cand  = 1'b0;
    cbase    = st.base;
    cds      = st.dstat;
    off      = '0;
    off_ext  = '0;

    unique case (st.phase)
      PH_SKIP: begin
        if (char_code != CH_SPACE) begin
          nxt.base = cfg_base;
          if (char_code == CH_MINUS) begin
            nxt.minus = 1'b1;
            nxt.phase = PH_AFTER_SIGN;
          end else if ((cfg_base == BASE_AUTO || cfg_base == BASE_HEX) &&
                       char_code == CH_ZERO) begin
            nxt.phase = PH_ZERO_PENDING;
          end else begin
            do_cand = 1'b1;
            cbase   = (cfg_base == BASE_AUTO) ? BASE_DECIMAL : cfg_base;
          end
        end
      end
      PH_AFTER_SIGN: begin
        if ((st.base == BASE_AUTO || st.base == BASE_HEX) && char_code == CH_ZERO) begin
          nxt.phase = PH_ZERO_PENDING;
        end else begin
          do_cand = 1'b1;
          cbase   = (st.base == BASE_AUTO) ? BASE_DECIMAL : st.base;
        end
      end
      PH_ZERO_PENDING: begin
        if (char_code == CH_LOWER_X || char_code == CH_UPPER_X) begin
          nxt.base  = BASE_HEX;
          nxt.phase = PH_DIGITS;
        end else begin
          // The held zero is a digit; accumulator stays zero
          do_cand   = 1'b1;
          cbase     = (st.base == BASE_AUTO) ? BASE_OCTAL : st.base;
          cds       = DS_SEEN;
          nxt.dstat = DS_SEEN;
        end
      end
      PH_DIGITS: begin
        do_cand = 1'b1;
        cbase   = (st.base == BASE_AUTO) ? BASE_DECIMAL : st.base;
      end
      default: begin
        nxt = PARSE_CLEAR;
      end
    endcase

    if (do_cand) begin
      nxt.base = cbase;
      if (is_digit) begin
        nxt.phase = PH_DIGITS;
        if (cds == DS_OVER || prod[PROD_W-1:VALUE_W] != '0) begin
          nxt.dstat = DS_OVER;
        end else begin
          nxt.dstat = DS_SEEN;
          nxt.acc   = prod[VALUE_W-1:0];
        end
      end else begin
        out.emit = 1'b1;
        if (cds == DS_OVER) begin
          out.res.value = ALL_ONES;
        end else if (st.minus) begin
          out.res.value = VALUE_W'(0) - st.acc;
        end else begin
          out.res.value = st.acc;
        end
        out.res.overflow    = (cds == DS_OVER);
        out.res.digits_seen = (cds != DS_NONE);
        off = {1'b0, st.pos} + (POS_W + 1)'(cds == DS_NONE);
        if (off > (POS_W + 1)'(MAX_TEXT_LENGTH)) begin
          off = (POS_W + 1)'(MAX_TEXT_LENGTH);
        end
        off_ext            = {{OFFSET_W{1'b0}}, off};
        out.res.end_offset = off_ext[OFFSET_W-1:0];
        nxt                = PARSE_CLEAR;
      end
    end

    if (!out.emit && st.pos < POS_W'(MAX_TEXT_LENGTH)) begin
      nxt.pos = st.pos + POS_W'(1);
    end
  end

endmodule
`default_nettype wire

/* sv/text_to_unsigned64_parser.sv */
// Top level of the streaming text-to-unsigned 64-bit parser.
//
//   channel  kind         word contents
//   -------  -----------  ------------------------------------------------
//   text     valid/ready  char_code: one text byte
//   number   valid/ready  value, overflow, digits_seen, end_offset
//   apb      APB          number_base register, index 0 at byte address 0
//
// One byte is taken every cycle unless a waiting result stalls: the loop through
// the parse state is a single 64x6 multiply-add and compare, combinational from
// the input register. A result is registered as its terminating byte leaves the
// input register, unless an older result still waits and holds the parse stage.
// Reset (synchronous, active high) clears the parse state and sets the radix to 10.
// A waiting result stalls the parse stage; one further byte may be taken
// into the input register meanwhile, then text.ready drops.
`default_nettype none
`include "text_to_unsigned64_parser_assert.svh"
module text_to_unsigned64_parser import tu64_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  tu64_byte_if.sink             text,
  tu64_result_if.source         number
);

  logic [BASE_W-1:0] number_base;

  // Input register
  logic              in_vld;
  logic [CHAR_W-1:0] in_char;

  // Parse state and step logic
  parse_state_t st;
  parse_state_t st_next;
  step_out_t    step;

  // Result register
  logic    out_vld;
  result_t out_res;

  logic fire;

  tu64_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .number_base (number_base)
  );

  tu64_parse_step u_step (
    .st        (st),
    .char_code (in_char),
    .cfg_base  (number_base),
    .nxt       (st_next),
    .out       (step)
  );

  // Advance the held byte unless a result still waits to be taken
  assign fire       = in_vld && (!out_vld || number.ready);
  assign text.ready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_char <= text.char_code;
    end
  end

  // Parse state: hold while stalled, step on every advanced byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_CLEAR;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Result register: load on a terminating byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire && step.emit) begin
      out_vld <= 1'b1;
    end else if (number.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.emit) begin
      out_res <= step.res;
    end
  end

  assign number.valid       = out_vld;
  assign number.value       = out_res.value;
  assign number.overflow    = out_res.overflow;
  assign number.digits_seen = out_res.digits_seen;
  assign number.end_offset  = out_res.end_offset;

  `TU64_ASSERT_NEXT(a_stall_holds_state, clk, rst, out_vld && !number.ready, $stable(st), "parse state moved while the result was stalled")
  `TU64_ASSERT_NEXT(a_emit_returns_idle, clk, rst, fire && step.emit, st.phase == PH_SKIP && st.pos == '0, "parser not idle after a result")
  `TU64_ASSERT(a_no_digit_result, clk, rst, !(out_vld && !out_res.digits_seen) || (out_res.value == '0 && !out_res.overflow), "result without digits has a value or overflow")
  `TU64_ASSERT(a_overflow_all_ones, clk, rst, !(out_vld && out_res.overflow) || out_res.value == ALL_ONES, "overflow result is not all ones")

endmodule
`default_nettype wire

/* tb/sv/tu64_number_check.sv */
// Scoreboard for the text-to-unsigned parser: mirrors the parse and checks every number word.
`timescale 1ns / 1ps
module tu64_number_check import tu64_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  tu64_byte_if                  text,
  tu64_result_if                number,
  output int                    mismatch_count,
  output int                    numbers_due
);

  localparam logic [APB_ADDR_W-1:0] BASE_ADDR  = {REG_NUMBER_BASE, 2'b00};
  localparam int                    PRINT_CAP  = 50;

  // Mirrored register and parse state
  logic [BASE_W-1:0]  radix_reg;
  phase_t             ph;
  logic [VALUE_W-1:0] acc;
  logic [BASE_W-1:0]  act_base;
  logic               neg;
  digit_status_t      dstat;
  logic [POS_W-1:0]   pos;
  logic               done;
  result_t            done_res;
  result_t            expected_numbers[$];

  function automatic int char_digit(logic [CHAR_W-1:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) return int'(b - CH_UPPER_A) + 10;
    if (b >= CH_LOWER_A && b <= CH_LOWER_Z) return int'(b - CH_LOWER_A) + 10;
    return -1;
  endfunction

  // An unlatched radix counts as ten.
  function automatic logic [VALUE_W-1:0] radix();
    return (act_base != BASE_AUTO) ? VALUE_W'(act_base) : VALUE_W'(BASE_DECIMAL);
  endfunction

  function automatic void clear_parse();
    ph       = PH_SKIP;
    acc      = '0;
    act_base = BASE_AUTO;
    neg      = 1'b0;
    dstat    = DS_NONE;
    pos      = '0;
  endfunction

  function automatic void take_digit(logic [VALUE_W-1:0] d);
    logic [VALUE_W-1:0] r;
    logic [VALUE_W-1:0] cut;
    logic [VALUE_W-1:0] lim;
    r   = radix();
    cut = ALL_ONES / r;
    lim = ALL_ONES % r;
    if (dstat == DS_OVER || acc > cut || (acc == cut && d > lim)) begin
      dstat = DS_OVER;
    end else begin
      dstat = DS_SEEN;
      acc   = acc * r + d;
    end
  endfunction

  // Accept the byte as a digit, or close the number on it.
  function automatic void digit_or_stop(logic [CHAR_W-1:0] b);
    int                d;
    logic [OFFSET_W:0] off;
    d = char_digit(b);
    if (d >= 0 && VALUE_W'(d) < radix()) begin
      take_digit(VALUE_W'(d));
      ph = PH_DIGITS;
    end else begin
      off = {1'b0, pos};
      if (dstat == DS_NONE) off = off + (OFFSET_W + 1)'(1);
      if (off > MAX_TEXT_LENGTH) off = (OFFSET_W + 1)'(MAX_TEXT_LENGTH);
      done                 = 1'b1;
      done_res.value       = (dstat == DS_OVER) ? ALL_ONES :
                             (neg ? (VALUE_W'(0) - acc) : acc);
      done_res.overflow    = (dstat == DS_OVER);
      done_res.digits_seen = (dstat != DS_NONE);
      done_res.end_offset  = off[OFFSET_W-1:0];
      clear_parse();
    end
  endfunction

  function automatic void lead_char(logic [CHAR_W-1:0] b);
    if ((act_base == BASE_AUTO || act_base == BASE_HEX) && b == CH_ZERO) begin
      ph = PH_ZERO_PENDING;
    end else begin
      if (act_base == BASE_AUTO) act_base = BASE_DECIMAL;
      digit_or_stop(b);
    end
  endfunction

  function automatic void parse_byte(logic [CHAR_W-1:0] b);
    done = 1'b0;
    case (ph)
      PH_SKIP: begin
        if (b != CH_SPACE) begin
          act_base = radix_reg;
          if (b == CH_MINUS) begin
            neg = 1'b1;
            ph  = PH_AFTER_SIGN;
          end else begin
            lead_char(b);
          end
        end
      end
      PH_AFTER_SIGN: lead_char(b);
      PH_ZERO_PENDING: begin
        if (b == CH_LOWER_X || b == CH_UPPER_X) begin
          act_base = BASE_HEX;
          ph       = PH_DIGITS;
        end else begin
          if (act_base == BASE_AUTO) act_base = BASE_OCTAL;
          take_digit('0);
          digit_or_stop(b);
        end
      end
      default: digit_or_stop(b);
    endcase
    if (!done && pos < MAX_TEXT_LENGTH) pos = pos + POS_W'(1);
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      radix_reg = BASE_DECIMAL;
      clear_parse();
      expected_numbers.delete();
      mismatch_count = 0;
    end else begin
      if (text.valid && text.ready) begin
        parse_byte(text.char_code);
        if (done) expected_numbers.push_back(done_res);
      end
      if (number.valid && number.ready) begin
        if (expected_numbers.size() == 0) begin
          report_mismatch("unexpected number word, value", number.value, '0);
        end else begin
          want = expected_numbers.pop_front();
          if (number.value !== want.value)
            report_mismatch("value", number.value, want.value);
          if (number.overflow !== want.overflow)
            report_mismatch("overflow", VALUE_W'(number.overflow),
                            VALUE_W'(want.overflow));
          if (number.digits_seen !== want.digits_seen)
            report_mismatch("digits_seen", VALUE_W'(number.digits_seen),
                            VALUE_W'(want.digits_seen));
          if (number.end_offset !== want.end_offset)
            report_mismatch("end_offset", VALUE_W'(number.end_offset),
                            VALUE_W'(want.end_offset));
        end
      end
      if (psel && penable && pready && paddr == BASE_ADDR) begin
        if (pwrite)
          radix_reg = pwdata[BASE_W-1:0];
        else if (prdata[BASE_W-1:0] !== radix_reg)
          report_mismatch("number_base readback", VALUE_W'(prdata), VALUE_W'(radix_reg));
      end
    end
    numbers_due <= int'(expected_numbers.size());
  end

endmodule

/* tb/sv/tb_text_to_unsigned64_parser.sv */
// Top of the text-to-unsigned parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_text_to_unsigned64_parser;
  import tu64_pkg::*;

  // Cycles to let a byte clear the input register and parse stage.
  localparam int unsigned SETTLE_CYCLES      = 8;
  // Upper bound on waiting for outstanding number words in one drain.
  localparam int unsigned DRAIN_LIMIT        = 20000;
  localparam int unsigned RANDOM_PHASE_BYTES = 85;
  localparam int unsigned DIGIT_SPAN_MAX     = 36;
  localparam int unsigned TIMEOUT_NS         = 5_000_000;

  localparam logic [APB_ADDR_W-1:0] BASE_ADDR = {REG_NUMBER_BASE, 2'b00};

  typedef enum int unsigned {STALL_NONE, STALL_COIN, STALL_CHOKE, STALL_COMB} stall_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tu64_byte_if   text_ch ();
  tu64_result_if number_ch ();

  int mismatch_count;
  int numbers_due;

  // Bytes waiting for the text driver, oldest first.
  logic [CHAR_W-1:0] text_bytes[$];
  int unsigned       bytes_queued;

  text_to_unsigned64_parser dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .text    (text_ch),
    .number  (number_ch)
  );

  tu64_number_check number_watch (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .text           (text_ch),
    .number         (number_ch),
    .mismatch_count (mismatch_count),
    .numbers_due    (numbers_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL text_to_unsigned64_parser");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Text driver: drain text_bytes in bursts of random length with random gaps.
  // Hold a word steady until it is taken; put junk on char_code while idle.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned burst_left;
    int unsigned gap_left;
    text_ch.valid     <= 1'b0;
    text_ch.char_code <= '0;
    burst_left = 1;
    gap_left   = 0;
    forever begin
      @(posedge clk);
      if (!(text_ch.valid && !text_ch.ready)) begin
        if (text_ch.valid) begin
          // The word on the bus was taken at this edge: advance.
          void'(text_bytes.pop_front());
          burst_left--;
          if (burst_left == 0) begin
            gap_left   = $urandom_range(1, 7);
            // Now and then a long burst, so stretches with no idling occur.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
          end
        end
        if (gap_left == 0 && text_bytes.size() != 0) begin
          text_ch.valid     <= 1'b1;
          text_ch.char_code <= text_bytes[0];
        end else begin
          if (gap_left != 0) gap_left--;
          text_ch.valid     <= 1'b0;
          text_ch.char_code <= CHAR_W'($urandom_range(0, 255));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Number receiver: stall on one of four patterns, picked again at random when the current one runs out.
  // ---------------------------------------------------------------------------
  initial begin
    stall_mode_t mode;
    int unsigned left;
    int unsigned tick;
    number_ch.ready <= 1'b0;
    mode = STALL_NONE;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      tick++;
      case (mode)
        STALL_NONE:  number_ch.ready <= 1'b1;
        STALL_COIN:  number_ch.ready <= 1'($urandom_range(0, 1));
        STALL_CHOKE: number_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     number_ch.ready <= ((tick % 7) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [CHAR_W-1:0] b);
    text_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Wait until every queued byte is taken and every number word has arrived,
  // then let the pipeline settle so the block is truly idle.
  task automatic drain_pipe();
    int unsigned waited;
    waited = 0;
    while (text_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (numbers_due != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer to number_base: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= BASE_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Change the radix only once the block is idle, then read it back.
  task automatic set_radix(input logic [BASE_W-1:0] rad);
    drain_pipe();
    apb_access(1'b1, APB_DATA_W'(rad));
    apb_access(1'b0, '0);
  endtask

  function automatic bit is_digit_of(logic [CHAR_W-1:0] b, logic [BASE_W-1:0] rad);
    int d;
    d = -1;
    if (b >= CH_ZERO && b <= CH_NINE) d = int'(b - CH_ZERO);
    else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) d = int'(b - CH_UPPER_A) + 10;
    else if (b >= CH_LOWER_A && b <= CH_LOWER_Z) d = int'(b - CH_LOWER_A) + 10;
    return d >= 0 && d < ((rad == BASE_AUTO) ? int'(BASE_DECIMAL) : int'(rad));
  endfunction

  function automatic logic [CHAR_W-1:0] digit_glyph(int unsigned d);
    if (d < 10) return CH_ZERO + CHAR_W'(d);
    return (($urandom_range(0, 1) != 0) ? CH_UPPER_A : CH_LOWER_A) + CHAR_W'(d - 10);
  endfunction

  // Pick a byte that ends a number in this radix; favour space and minus.
  function automatic logic [CHAR_W-1:0] stop_glyph(logic [BASE_W-1:0] rad);
    logic [CHAR_W-1:0] b;
    int unsigned       pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) b = CH_SPACE;
    else if (pick == 1) b = CH_MINUS;
    else b = CHAR_W'($urandom_range(0, 255));
    while (is_digit_of(b, rad)) b = CHAR_W'($urandom_range(0, 255));
    return b;
  endfunction

  // A well-formed number with random content: spaces, sign, prefix, digits,
  // terminator. Zero digits gives the broken forms (bare sign, bare prefix).
  task automatic queue_number(input logic [BASE_W-1:0] cfg);
    logic [BASE_W-1:0] rad;
    int unsigned       n;
    int unsigned       span;
    int unsigned       kind;
    int unsigned       d;
    rad  = cfg;
    kind = $urandom_range(0, 2);
    repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
    if ($urandom_range(0, 3) == 0) push_byte(CH_MINUS);
    if ((cfg == BASE_AUTO || cfg == BASE_HEX) && kind == 0) begin
      push_byte(CH_ZERO);
      push_byte(($urandom_range(0, 1) != 0) ? CH_LOWER_X : CH_UPPER_X);
      rad = BASE_HEX;
    end else if (cfg == BASE_AUTO && kind == 1) begin
      push_byte(CH_ZERO);
      rad = BASE_OCTAL;
    end else if (cfg == BASE_AUTO) begin
      rad = BASE_DECIMAL;
    end
    span = (rad > DIGIT_SPAN_MAX) ? DIGIT_SPAN_MAX : rad;
    // Mostly short numbers; sometimes long runs, which can overflow.
    n = ($urandom_range(0, 6) == 0) ? $urandom_range(12, 70) : $urandom_range(0, 10);
    for (int unsigned i = 0; i < n; i++) begin
      if (cfg == BASE_AUTO && kind == 2 && i == 0)
        d = $urandom_range(1, 9);
      else
        d = ($urandom_range(0, 1) != 0) ? span - 1 : $urandom_range(0, span - 1);
      push_byte(digit_glyph(d));
    end
    push_byte(stop_glyph(rad));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [BASE_W-1:0] radix_plan[8];
    int unsigned       start;
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    bytes_queued = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Confirm the radix comes out of reset as ten, then parse in it.
    apb_access(1'b0, '0);
    push_str("  123 ");
    push_str("-45,");
    push_str("18446744073709551615;");
    push_str("18446744073709551616;");
    // Overflow after a minus: all ones, not negated.
    push_str("-99999999999999999999;");
    push_str("a");
    push_str("- ");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_str("9");
    push_byte(8'h80);
    push_str("0x1 ");

    // Auto-detection: hex prefix, bare prefix, octal, zero then no x.
    set_radix(BASE_AUTO);
    push_str("0x1fZ");
    push_str("0X7g");
    push_str("0x;");
    push_str("017;");
    push_str("08");
    push_str("-0x10 ");
    push_str("42 ");
    push_str("-0 ");

    set_radix(BASE_HEX);
    push_str("0xFFFFFFFFFFFFFFFF;");
    push_str("0x10000000000000000;");
    push_str("-1 ");
    push_str("0;");

    set_radix(6'd36);
    push_str("zZ;");
    push_str("ZZZZZZZZZZZZZZ;");

    set_radix(6'd2);
    push_str("1010 2");

    // Radices outside 2..36 are used as given.
    set_radix(6'd1);
    push_str("000 1");
    set_radix(6'd63);
    push_str("zZ9!");
    set_radix(6'd37);
    push_str("a0-");

    // Write the radix while a number is half parsed: only the next one sees it.
    set_radix(BASE_DECIMAL);
    push_str("12");
    set_radix(BASE_HEX);
    push_str("a a;");

    // Random phases over several radices, extremes among them.
    radix_plan[0] = BASE_AUTO;
    radix_plan[1] = BASE_HEX;
    radix_plan[2] = BASE_DECIMAL;
    radix_plan[3] = 6'd2;
    radix_plan[4] = 6'd36;
    radix_plan[5] = 6'd63;
    radix_plan[6] = BASE_W'($urandom_range(0, 63));
    radix_plan[7] = BASE_OCTAL;
    for (int p = 0; p < 8; p++) begin
      set_radix(radix_plan[p]);
      start = bytes_queued;
      while (bytes_queued - start < RANDOM_PHASE_BYTES) begin
        if ($urandom_range(0, 6) == 0)
          repeat ($urandom_range(1, 4)) push_byte(CHAR_W'($urandom_range(0, 255)));
        else
          queue_number(radix_plan[p]);
      end
    end

    drain_pipe();
    // Anything still expected at this point is a lost number word.
    if (mismatch_count == 0 && numbers_due == 0) begin
      $display("PASS text_to_unsigned64_parser");
    end else begin
      $display("FAIL text_to_unsigned64_parser");
    end
    $finish;
  end

endmodule

/* text_to_unsigned64_parser.f */
+incdir+sv
sv/tu64_pkg.sv
sv/tu64_byte_if.sv
sv/tu64_result_if.sv
sv/tu64_apb_regs.sv
sv/tu64_parse_step.sv
sv/text_to_unsigned64_parser.sv
tb/sv/tu64_number_check.sv
tb/sv/tb_text_to_unsigned64_parser.sv
